[rtl/core/ascn_pkg.sv]
// ============================================================================
// ascn_pkg - shared types and constants for the stick calibrate/normalise block
// Mode codes, register indexes, scale constants and the control state type.
// ============================================================================
`default_nettype none

package ascn_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_BITS = 12;
   localparam int POS_BITS    = 8;
   localparam int CSR_IDX_BITS = 3;

   // Item modes
   localparam logic [1:0] MODE_MEASURE   = 2'd0;
   localparam logic [1:0] MODE_CALIBRATE = 2'd1;
   localparam logic [1:0] MODE_CLEAR     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_STICK_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STICK_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STICK_Y_LOW  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STICK_Y_HIGH = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLIDE_X_LOW  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLIDE_X_HIGH = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLIDE_Y_LOW  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLIDE_Y_HIGH = 3'd7;

   // Full scale per device
   localparam logic [POS_BITS-1:0] STICK_FULL = 8'd100;
   localparam logic [POS_BITS-1:0] SLIDE_FULL = 8'd255;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } ctl_state_type;

endpackage

`default_nettype wire

[rtl/core/analog_stick_calibrate_normalize.sv]
// ============================================================================
// analog_stick_calibrate_normalize - min/max autocalibration and scaling
// Two-axis ADC samples for a stick or a slider pair, scaled to 0..100 / 0..255.
// ============================================================================
// Usage:
//  - req_ channel (valid/stall) carries one beat per item: mode, device,
//    x/y sample and the active-low button pin.
//  - Calibrate and clear beats update the per-device limits at the accepting
//    edge and give no rsp_ beat.
//  - A measure beat gives one rsp_ beat. Both axes run side by side in a
//    restoring divider, one quotient bit per cycle: a clamp/product step,
//    the divide, then the load into the output register. req_stall is high
//    from acceptance until the result is loaded, so the next item is taken
//    only after that load; an axis that clamps skips the divide, and the load
//    also waits while the previous result sits stalled in the output register.
//  - The output register parts the two sides: a waiting result does not
//    block the next item; a finished result only waits for a free register.
//  - rsp_stall holds the output beat steady until it is taken.
//  - csr_ writes load the default limits; use them only while idle.
//  - Reset (synchronous): uncalibrated, defaults low 0 / high full range,
//    no pending result. No clearing pass.
// ============================================================================
`default_nettype none

module analog_stick_calibrate_normalize
   import ascn_pkg::*;
#(
   parameter int ADC_BITS = 12
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // item beats
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic                         req_device,
   input  logic [SAMPLE_BITS-1:0]       req_sample_x,
   input  logic [SAMPLE_BITS-1:0]       req_sample_y,
   input  logic                         req_button_level,
   // result beats
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [POS_BITS-1:0]          rsp_pos_x,
   output logic [POS_BITS-1:0]          rsp_pos_y,
   output logic                         rsp_pressed,
   output logic                         rsp_out_device,
   // register writes
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [SAMPLE_BITS-1:0]       csr_wdata
);

   // Effective sample width: the port width masked down to ADC_BITS
   localparam int VB = (ADC_BITS < SAMPLE_BITS) ? ADC_BITS : SAMPLE_BITS;

   // default limit registers
   logic [VB-1:0] stick_xl_ff, stick_xh_ff, stick_yl_ff, stick_yh_ff;
   logic [VB-1:0] slide_xl_ff, slide_xh_ff, slide_yl_ff, slide_yh_ff;

   // calibrated limits, one entry per device
   logic [VB-1:0] cal_xl_ff [2];
   logic [VB-1:0] cal_xh_ff [2];
   logic [VB-1:0] cal_yl_ff [2];
   logic [VB-1:0] cal_yh_ff [2];
   logic [1:0]    cal_valid_ff;

   ctl_state_type state_ff, state_in;
   logic          accept, start, load, out_free;
   logic          dev_ff, pressed_ff;

   logic [VB-1:0] sx, sy;
   logic [VB-1:0] lim_xl, lim_xh, lim_yl, lim_yh;

   logic [POS_BITS-1:0] x_q, y_q;
   logic                x_done, y_done;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0] pos_x_ff, pos_y_ff;
   logic                rsp_pressed_ff, rsp_device_ff;

   assign sx = req_sample_x[VB-1:0];
   assign sy = req_sample_y[VB-1:0];

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_xl_ff <= '0;
         stick_xh_ff <= '1;
         stick_yl_ff <= '0;
         stick_yh_ff <= '1;
         slide_xl_ff <= '0;
         slide_xh_ff <= '1;
         slide_yl_ff <= '0;
         slide_yh_ff <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STICK_X_LOW:  stick_xl_ff <= csr_wdata[VB-1:0];
            CSR_STICK_X_HIGH: stick_xh_ff <= csr_wdata[VB-1:0];
            CSR_STICK_Y_LOW:  stick_yl_ff <= csr_wdata[VB-1:0];
            CSR_STICK_Y_HIGH: stick_yh_ff <= csr_wdata[VB-1:0];
            CSR_SLIDE_X_LOW:  slide_xl_ff <= csr_wdata[VB-1:0];
            CSR_SLIDE_X_HIGH: slide_xh_ff <= csr_wdata[VB-1:0];
            CSR_SLIDE_Y_LOW:  slide_yl_ff <= csr_wdata[VB-1:0];
            CSR_SLIDE_Y_HIGH: slide_yh_ff <= csr_wdata[VB-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------- control
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign start    = accept && (req_mode == MODE_MEASURE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            req_stall = 1'b1;
            // the axes can finish apart; wait for both and for a free output slot
            if (x_done && y_done && out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ----------------------------------------------------------- calibration
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_valid_ff <= '0;
      end else if (accept) begin
         if (req_mode == MODE_CALIBRATE) begin
            cal_valid_ff[req_device] <= 1'b1;
         end else if (req_mode == MODE_CLEAR) begin
            cal_valid_ff[req_device] <= 1'b0;
         end
      end
   end

   // limit values: only read while their valid bit is set, so no reset
   always_ff @(posedge clock) begin
      if (accept && (req_mode == MODE_CALIBRATE)) begin
         if (!cal_valid_ff[req_device]) begin
            // first sample seeds both limits
            cal_xl_ff[req_device] <= sx;
            cal_xh_ff[req_device] <= sx;
            cal_yl_ff[req_device] <= sy;
            cal_yh_ff[req_device] <= sy;
         end else begin
            if (sx < cal_xl_ff[req_device]) cal_xl_ff[req_device] <= sx;
            if (sx > cal_xh_ff[req_device]) cal_xh_ff[req_device] <= sx;
            if (sy < cal_yl_ff[req_device]) cal_yl_ff[req_device] <= sy;
            if (sy > cal_yh_ff[req_device]) cal_yh_ff[req_device] <= sy;
         end
      end
   end

   // limits for a measure beat: calibrated if present, else defaults
   always_comb begin
      if (cal_valid_ff[req_device]) begin
         lim_xl = cal_xl_ff[req_device];
         lim_xh = cal_xh_ff[req_device];
         lim_yl = cal_yl_ff[req_device];
         lim_yh = cal_yh_ff[req_device];
      end else if (req_device) begin
         lim_xl = slide_xl_ff;
         lim_xh = slide_xh_ff;
         lim_yl = slide_yl_ff;
         lim_yh = slide_yh_ff;
      end else begin
         lim_xl = stick_xl_ff;
         lim_xh = stick_xh_ff;
         lim_yl = stick_yl_ff;
         lim_yh = stick_yh_ff;
      end
   end

   // ----------------------------------------------------------------- axes
   ascn_axis #(.VALUE_BITS(VB)) u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .value  (sx),
      .low    (lim_xl),
      .high   (lim_xh),
      .slide  (req_device),
      .result (x_q),
      .done   (x_done)
   );

   ascn_axis #(.VALUE_BITS(VB)) u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .value  (sy),
      .low    (lim_yl),
      .high   (lim_yh),
      .slide  (req_device),
      .result (y_q),
      .done   (y_done)
   );

   // device and button travel alongside the divide
   always_ff @(posedge clock) begin
      if (start) begin
         dev_ff     <= req_device;
         pressed_ff <= !req_device && !req_button_level;
      end
   end

   // -------------------------------------------------------------- output
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_x_ff       <= x_q;
         pos_y_ff       <= y_q;
         rsp_pressed_ff <= pressed_ff;
         rsp_device_ff  <= dev_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_pressed    = rsp_pressed_ff;
   assign rsp_out_device = rsp_device_ff;

endmodule

`default_nettype wire

[rtl/core/ascn_axis.sv]
// ============================================================================
// ascn_axis - one axis clamp and linear scale
// Clamps a sample to its limits, forms (v-low)*full and divides it by
// (high-low) in a restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module ascn_axis
   import ascn_pkg::*;
#(
   parameter int VALUE_BITS = 12
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  logic                       start,
   input  logic [VALUE_BITS-1:0]      value,
   input  logic [VALUE_BITS-1:0]      low,
   input  logic [VALUE_BITS-1:0]      high,
   input  logic                       slide,
   output logic [POS_BITS-1:0]        result,
   output logic                       done
);

   localparam int NW = VALUE_BITS + POS_BITS;
   localparam int SW = $clog2(POS_BITS);
   localparam logic [SW-1:0] STEP_TOP = SW'(POS_BITS - 1);

   logic [VALUE_BITS-1:0] value_ff, low_ff, high_ff, div_ff;
   logic                  slide_ff;
   logic [NW-1:0]         rem_ff;
   logic [POS_BITS-1:0]   quot_ff;
   logic [SW-1:0]         step_ff;
   logic                  prep_ff, iter_ff, done_ff;

   logic [POS_BITS-1:0]   full;
   logic [VALUE_BITS-1:0] delta;
   logic [NW-1:0]         delta_w, numer, trial;
   logic                  fits;

   always_comb begin
      full    = slide_ff ? SLIDE_FULL : STICK_FULL;
      delta   = value_ff - low_ff;
      delta_w = NW'(delta);
      // x255 = x256 - x ; x100 = x64 + x32 + x4
      if (slide_ff) begin
         numer = {delta, POS_BITS'(0)} - delta_w;
      end else begin
         numer = (delta_w << 6) + (delta_w << 5) + (delta_w << 2);
      end
      trial = NW'(div_ff) << step_ff;
      fits  = (rem_ff >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         iter_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         value_ff <= value;
         low_ff   <= low;
         high_ff  <= high;
         slide_ff <= slide;
         prep_ff  <= 1'b1;
         iter_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else if (prep_ff) begin
         prep_ff <= 1'b0;
         if (value_ff <= low_ff) begin
            quot_ff <= '0;
            done_ff <= 1'b1;
         end else if (value_ff >= high_ff) begin
            quot_ff <= full;
            done_ff <= 1'b1;
         end else begin
            rem_ff  <= numer;
            div_ff  <= high_ff - low_ff;
            quot_ff <= '0;
            step_ff <= STEP_TOP;
            iter_ff <= 1'b1;
         end
      end else if (iter_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - trial;
         end
         quot_ff <= {quot_ff[POS_BITS-2:0], fits};
         if (step_ff == '0) begin
            iter_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   assign result = quot_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire
